// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL. Each one samples on clk and is
// disabled while rst is high, so the user module must have both in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset.
`define SIT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SIT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`else

`define SIT_ASSERT(lbl, cond, msg)
`define SIT_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

// ===== src/sit_pkg.sv =====
package sit_pkg;

  // Width of every coordinate field on the ports.
  localparam int FIELD_W = 32;

  // Default number of coordinate bits that are actually used.
  localparam int COORD_WIDTH_DEF = 32;

  typedef struct packed {
    logic signed [FIELD_W-1:0] first_start_x;
    logic signed [FIELD_W-1:0] first_start_y;
    logic signed [FIELD_W-1:0] first_end_x;
    logic signed [FIELD_W-1:0] first_end_y;
    logic signed [FIELD_W-1:0] second_start_x;
    logic signed [FIELD_W-1:0] second_start_y;
    logic signed [FIELD_W-1:0] second_end_x;
    logic signed [FIELD_W-1:0] second_end_y;
  } seg_word_t;

  typedef struct packed {
    logic                      hit;
    logic                      parallel;
    logic signed [FIELD_W-1:0] cross_x;
    logic signed [FIELD_W-1:0] cross_y;
  } res_word_t;

endpackage

// ===== src/sit_div.sv =====
// Pipelined restoring divider. The first stage checks whether the quotient
// needs more than W+1 bits (overflow); the next W+1 stages each produce one
// quotient bit.
module sit_div #(
  parameter int W = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [3*W+1:0]     num,
  input  logic [2*W+1:0]     den,
  output logic [W:0]         quo,
  output logic               ovf
);

  localparam int C = W + 1;
  localparam int M = 2 * W + 2;
  localparam int P = 3 * W + 2;

  logic [M-1:0] rem_s [0:C];
  logic [C-1:0] quo_s [0:C];
  logic [C-1:0] low_s [0:C];
  logic [M-1:0] den_s [0:C];
  logic         ovf_s [0:C];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= M'(num[P-1:C]);
      quo_s[0] <= '0;
      low_s[0] <= num[C-1:0];
      den_s[0] <= den;
      ovf_s[0] <= (M'(num[P-1:C]) >= den);
    end
  end

  for (genvar k = 0; k < C; k++) begin : g_stage
    logic         nbit;
    logic [M+1:0] diff;
    logic         ge;

    assign nbit = low_s[k][W-k];
    assign diff = {1'b0, rem_s[k], nbit} - {2'b00, den_s[k]};
    assign ge   = ~diff[M+1];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? diff[M-1:0] : {rem_s[k][M-2:0], nbit};
        quo_s[k+1] <= {quo_s[k][C-2:0], ge};
        low_s[k+1] <= low_s[k];
        den_s[k+1] <= den_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  assign quo = quo_s[C];
  assign ovf = ovf_s[C];

endmodule

// ===== src/segment_intersection_test_unit.sv =====
// Channel  Valid      Stall      Word                  Meaning
// -------  ---------  ---------  --------------------  ---------------------------
// seg      seg_valid  seg_stall  seg (seg_word_t)      two segments, four endpoints
// res      res_valid  res_stall  res (res_word_t)      hit, parallel, crossing point
//
// One segment pair is taken per cycle while seg_stall is low; the quotient
// pipeline produces one bit per stage.
// Reset (rst, synchronous) clears only the valid bits; no clearing pass.
// Output register plus one skid word: while a result is held the pipeline runs
// on until the next valid word reaches the final register; that word moves to
// the skid register, and seg_stall, driven from it, stays high until the
// output register takes the skid word.
`include "assert_macros.svh"

module segment_intersection_test_unit #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              seg_valid,
  output logic              seg_stall,
  input  sit_pkg::seg_word_t seg,
  output logic              res_valid,
  input  logic              res_stall,
  output sit_pkg::res_word_t res
);

  // W coordinate bits, C bits for a difference, M bits for the magnitude of a
  // cross product (M1 with sign), P bits for the magnitude of R times t-num.
  localparam int W  = COORD_WIDTH;
  localparam int C  = W + 1;
  localparam int C2 = 2 * C;
  localparam int M  = 2 * W + 2;
  localparam int M1 = M + 1;
  localparam int P  = 3 * W + 2;
  localparam int C3 = 3 * C;
  localparam int V  = W + 3;
  localparam int Q  = W + 2;

  // The whole pipeline moves together; it halts only while the skid word is
  // occupied, so the intake stall comes straight from a flop.
  logic en;
  logic skid_valid;
  assign en        = ~skid_valid;
  assign seg_stall = skid_valid;

  // Stage 1: take the low W bits of each coordinate and form the direction
  // vectors R, S and the start offset D = Q - P.
  logic                s1_valid;
  logic signed [W-1:0] s1_px, s1_py;
  logic signed [C-1:0] s1_rx, s1_ry, s1_sx, s1_sy, s1_dx, s1_dy;

  logic signed [W-1:0] c_px, c_py, c_ex, c_ey, c_qx, c_qy, c_fx, c_fy;
  assign c_px = seg.first_start_x[W-1:0];
  assign c_py = seg.first_start_y[W-1:0];
  assign c_ex = seg.first_end_x[W-1:0];
  assign c_ey = seg.first_end_y[W-1:0];
  assign c_qx = seg.second_start_x[W-1:0];
  assign c_qy = seg.second_start_y[W-1:0];
  assign c_fx = seg.second_end_x[W-1:0];
  assign c_fy = seg.second_end_y[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= seg_valid;
    end
    if (en) begin
      s1_px <= c_px;
      s1_py <= c_py;
      s1_rx <= C'(c_ex) - C'(c_px);
      s1_ry <= C'(c_ey) - C'(c_py);
      s1_sx <= C'(c_fx) - C'(c_qx);
      s1_sy <= C'(c_fy) - C'(c_qy);
      s1_dx <= C'(c_qx) - C'(c_px);
      s1_dy <= C'(c_qy) - C'(c_py);
    end
  end

  // Stage 2: the six partial products of the three cross products.
  logic                 s2_valid;
  logic signed [W-1:0]  s2_px, s2_py;
  logic signed [C-1:0]  s2_rx, s2_ry;
  logic signed [C2-1:0] s2_rs_a, s2_rs_b, s2_ts_a, s2_ts_b, s2_us_a, s2_us_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_px   <= s1_px;
      s2_py   <= s1_py;
      s2_rx   <= s1_rx;
      s2_ry   <= s1_ry;
      s2_rs_a <= s1_rx * s1_sy;
      s2_rs_b <= s1_ry * s1_sx;
      s2_ts_a <= s1_dx * s1_sy;
      s2_ts_b <= s1_dy * s1_sx;
      s2_us_a <= s1_dx * s1_ry;
      s2_us_b <= s1_dy * s1_rx;
    end
  end

  // Stage 3: denominator RxS and the numerators of t and u.
  logic                 s3_valid;
  logic signed [W-1:0]  s3_px, s3_py;
  logic signed [C-1:0]  s3_rx, s3_ry;
  logic signed [M1-1:0] s3_den, s3_tn, s3_un;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_px  <= s2_px;
      s3_py  <= s2_py;
      s3_rx  <= s2_rx;
      s3_ry  <= s2_ry;
      s3_den <= M1'(s2_rs_a) - M1'(s2_rs_b);
      s3_tn  <= M1'(s2_ts_a) - M1'(s2_ts_b);
      s3_un  <= M1'(s2_us_a) - M1'(s2_us_b);
    end
  end

  // Stage 4: magnitudes and signs. The t and u numerators are also brought
  // to a positive denominator so the range test is a plain compare.
  logic                 s4_valid;
  logic signed [W-1:0]  s4_px, s4_py;
  logic [C-1:0]         s4_rxm, s4_rym;
  logic                 s4_xneg, s4_yneg;
  logic [M-1:0]         s4_dm, s4_tm;
  logic signed [M1-1:0] s4_tn, s4_un;
  logic                 s4_par;

  logic dneg, tneg;
  assign dneg = s3_den[M1-1];
  assign tneg = s3_tn[M1-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
    if (en) begin
      s4_px   <= s3_px;
      s4_py   <= s3_py;
      s4_rxm  <= s3_rx[C-1] ? C'(-s3_rx) : C'(s3_rx);
      s4_rym  <= s3_ry[C-1] ? C'(-s3_ry) : C'(s3_ry);
      s4_xneg <= s3_rx[C-1] ^ tneg ^ dneg;
      s4_yneg <= s3_ry[C-1] ^ tneg ^ dneg;
      s4_dm   <= dneg ? M'(-s3_den) : M'(s3_den);
      s4_tm   <= tneg ? M'(-s3_tn) : M'(s3_tn);
      s4_tn   <= dneg ? -s3_tn : s3_tn;
      s4_un   <= dneg ? -s3_un : s3_un;
      s4_par  <= (s3_den == '0);
    end
  end

  // Stage 5: range test for the hit flag, and |R| times |t-num| split into
  // two narrow partial products per axis.
  logic               s5_valid;
  logic signed [W-1:0] s5_px, s5_py;
  logic               s5_xneg, s5_yneg, s5_hit, s5_par;
  logic [M-1:0]       s5_dm;
  logic [C2-1:0]      s5_xlo, s5_xhi, s5_ylo, s5_yhi;

  logic signed [M1-1:0] dm_s;
  logic                 t_in, u_in;
  assign dm_s = $signed({1'b0, s4_dm});
  assign t_in = (s4_tn > 0) && (s4_tn < dm_s);
  assign u_in = (s4_un > 0) && (s4_un < dm_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
    if (en) begin
      s5_px   <= s4_px;
      s5_py   <= s4_py;
      s5_xneg <= s4_xneg;
      s5_yneg <= s4_yneg;
      s5_hit  <= t_in && u_in && !s4_par;
      s5_par  <= s4_par;
      s5_dm   <= s4_dm;
      s5_xlo  <= s4_rxm * s4_tm[C-1:0];
      s5_xhi  <= s4_rxm * s4_tm[M-1:C];
      s5_ylo  <= s4_rym * s4_tm[C-1:0];
      s5_yhi  <= s4_rym * s4_tm[M-1:C];
    end
  end

  // Stage 6: combine the partial products into the full dividends.
  typedef struct packed {
    logic                valid;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    logic                xneg;
    logic                yneg;
    logic                hit;
    logic                par;
  } side_t;

  side_t        s6_side;
  logic [M-1:0] s6_dm;
  logic [P-1:0] s6_xnum, s6_ynum;
  logic [C3-1:0] xsum, ysum;

  assign xsum = C3'(s5_xlo) + (C3'(s5_xhi) << C);
  assign ysum = C3'(s5_ylo) + (C3'(s5_yhi) << C);

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_side.valid <= 1'b0;
    end else if (en) begin
      s6_side.valid <= s5_valid;
    end
    if (en) begin
      s6_side.px   <= s5_px;
      s6_side.py   <= s5_py;
      s6_side.xneg <= s5_xneg;
      s6_side.yneg <= s5_yneg;
      s6_side.hit  <= s5_hit;
      s6_side.par  <= s5_par;
      s6_dm        <= s5_dm;
      s6_xnum      <= xsum[P-1:0];
      s6_ynum      <= ysum[P-1:0];
    end
  end

  // Quotient pipelines, one per axis, with the side data riding alongside.
  logic [C-1:0] xquo, yquo;
  logic         xovf, yovf;

  sit_div #(.W(W)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (s6_xnum),
    .den (s6_dm),
    .quo (xquo),
    .ovf (xovf)
  );

  sit_div #(.W(W)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (s6_ynum),
    .den (s6_dm),
    .quo (yquo),
    .ovf (yovf)
  );

  side_t side_q [0:C];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= C; i++) begin
        side_q[i].valid <= 1'b0;
      end
    end else if (en) begin
      side_q[0].valid <= s6_side.valid;
      for (int i = 0; i < C; i++) begin
        side_q[i+1].valid <= side_q[i].valid;
      end
    end
    if (en) begin
      side_q[0].px   <= s6_side.px;
      side_q[0].py   <= s6_side.py;
      side_q[0].xneg <= s6_side.xneg;
      side_q[0].yneg <= s6_side.yneg;
      side_q[0].hit  <= s6_side.hit;
      side_q[0].par  <= s6_side.par;
      for (int i = 0; i < C; i++) begin
        side_q[i+1].px   <= side_q[i].px;
        side_q[i+1].py   <= side_q[i].py;
        side_q[i+1].xneg <= side_q[i].xneg;
        side_q[i+1].yneg <= side_q[i].yneg;
        side_q[i+1].hit  <= side_q[i].hit;
        side_q[i+1].par  <= side_q[i].par;
      end
    end
  end

  // Final stage: apply the quotient sign, add the start point and saturate
  // to the W-bit coordinate range. A parallel pair reports the origin.
  side_t side_o;
  assign side_o = side_q[C];

  logic signed [Q-1:0] xq_s, yq_s;
  logic signed [V-1:0] xv, yv;
  logic signed [W-1:0] xc, yc;
  logic                x_ok, y_ok;

  assign xq_s = side_o.xneg ? -$signed({1'b0, xquo}) : $signed({1'b0, xquo});
  assign yq_s = side_o.yneg ? -$signed({1'b0, yquo}) : $signed({1'b0, yquo});
  assign xv   = V'(side_o.px) + V'(xq_s);
  assign yv   = V'(side_o.py) + V'(yq_s);
  assign x_ok = !xovf && ((&xv[V-1:W-1]) || !(|xv[V-1:W-1]));
  assign y_ok = !yovf && ((&yv[V-1:W-1]) || !(|yv[V-1:W-1]));

  always_comb begin
    if (side_o.par) begin
      xc = '0;
    end else if (x_ok) begin
      xc = xv[W-1:0];
    end else if (xovf ? side_o.xneg : xv[V-1]) begin
      xc = {1'b1, {(W-1){1'b0}}};
    end else begin
      xc = {1'b0, {(W-1){1'b1}}};
    end
    if (side_o.par) begin
      yc = '0;
    end else if (y_ok) begin
      yc = yv[W-1:0];
    end else if (yovf ? side_o.yneg : yv[V-1]) begin
      yc = {1'b1, {(W-1){1'b0}}};
    end else begin
      yc = {1'b0, {(W-1){1'b1}}};
    end
  end

  logic               fin_valid;
  sit_pkg::res_word_t fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= side_o.valid;
    end
    if (en) begin
      fin.hit      <= side_o.hit;
      fin.parallel <= side_o.par;
      fin.cross_x  <= sit_pkg::FIELD_W'(xc);
      fin.cross_y  <= sit_pkg::FIELD_W'(yc);
    end
  end

  // Output register with one skid word. The skid only fills when the output
  // is held and the pipeline pushes a word in the same cycle.
  sit_pkg::res_word_t skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid  <= skid_valid || fin_valid;
      skid_valid <= 1'b0;
    end else if (en && fin_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      res <= skid_valid ? skid : fin;
    end else if (en && fin_valid) begin
      skid <= fin;
    end
  end

  `SIT_ASSERT_IMPL(a_par_clean, res_valid && res.parallel,
    !res.hit && res.cross_x == 0 && res.cross_y == 0, "parallel word not cleared")
  `SIT_ASSERT_IMPL(a_skid_behind_out, skid_valid, res_valid,
    "skid word held without an output word")
  `SIT_ASSERT_IMPL(a_skid_stalls_in, skid_valid, seg_stall,
    "intake open while skid word is held")

endmodule

// ===== verif/tb_segment_intersection_test_unit.sv =====
`timescale 1ns / 100ps

// Testbench for the segment crossing unit. Segment pairs go in on the seg
// channel, one word per handshake; each accepted word gets an expected result
// from the directed table or the predictor below, and the result words that
// come out are compared in order, field by field.
module tb_segment_intersection_test_unit;

  typedef logic signed [127:0] wide_t;

  // A row of the directed table. Where check_typed is set, the expected word
  // is the one written in the row; otherwise the predictor supplies it.
  typedef struct packed {
    sit_pkg::seg_word_t w;
    logic               check_typed;
    sit_pkg::res_word_t r;
  } row_t;

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] TWO  = 32'sh0002_0000;
  localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINC = 32'sh8000_0000;
  localparam logic signed [31:0] ZERO = 32'sh0;
  localparam int LATENCY    = sit_pkg::COORD_WIDTH_DEF + 9;
  localparam int CYCLE_CAP  = 600000;
  localparam int RAND_WORDS = 880;

  // Kinds of random segment pair.
  typedef enum int {
    PAIR_ANY, PAIR_SMALL, PAIR_CROSSING, PAIR_PARALLEL, PAIR_SHARED, PAIR_NEAR
  } pair_kind_e;

  logic               clk;
  logic               rst;
  logic               seg_valid;
  logic               seg_stall;
  sit_pkg::seg_word_t seg;
  logic               res_valid;
  logic               res_stall;
  sit_pkg::res_word_t res;

  sit_pkg::res_word_t expected_q[$];
  int                 error_count;
  int                 cycle_count;
  int                 stall_hold;
  bit                 no_idle;

  segment_intersection_test_unit dut (
    .clk(clk), .rst(rst),
    .seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // True when num/den lies strictly between zero and one.
  function automatic bit strictly_inside(wide_t num, wide_t den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    return (num > 0) && (num < den);
  endfunction

  // Base plus dir*num/den, rounded toward zero, clamped to 32-bit range.
  function automatic logic signed [31:0] clamp_point(wide_t base, wide_t dir,
                                                      wide_t num, wide_t den);
    wide_t v;
    wide_t lo_lim;
    wide_t hi_lim;
    lo_lim = $signed(MINC);
    hi_lim = $signed(MAXC);
    v = base + (dir * num) / den;
    if (v < lo_lim) v = lo_lim;
    if (v > hi_lim) v = hi_lim;
    return v[31:0];
  endfunction

  // Crossing test on exact wide integers: direction cross product first,
  // then both line parameters and the point on the first segment's line.
  function automatic sit_pkg::res_word_t predict_crossing(sit_pkg::seg_word_t w);
    wide_t px, py, rx, ry, qx, qy, sx, sy, dx, dy, den, tn, un;
    sit_pkg::res_word_t r;
    px = $signed(w.first_start_x);
    py = $signed(w.first_start_y);
    qx = $signed(w.second_start_x);
    qy = $signed(w.second_start_y);
    rx = wide_t'($signed(w.first_end_x)) - px;
    ry = wide_t'($signed(w.first_end_y)) - py;
    sx = wide_t'($signed(w.second_end_x)) - qx;
    sy = wide_t'($signed(w.second_end_y)) - qy;
    dx = qx - px;
    dy = qy - py;
    den = rx * sy - ry * sx;
    r = '0;
    if (den == 0) begin
      r.parallel = 1'b1;
      return r;
    end
    tn = dx * sy - dy * sx;
    un = dx * ry - dy * rx;
    r.hit = strictly_inside(tn, den) && strictly_inside(un, den);
    r.cross_x = clamp_point(px, rx, tn, den);
    r.cross_y = clamp_point(py, ry, tn, den);
    return r;
  endfunction

  function automatic logic signed [31:0] rand_small();
    return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  function automatic sit_pkg::seg_word_t random_pair(pair_kind_e kind);
    sit_pkg::seg_word_t w;
    logic signed [31:0] cx, cy, ax, ay, bx, by;
    int k;
    w = {$urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom};
    cx = rand_small();
    cy = rand_small();
    ax = rand_small();
    ay = rand_small();
    bx = rand_small();
    by = rand_small();
    k = $urandom_range(1, 4);
    case (kind)
      PAIR_SMALL: begin
        w = {cx, cy, ax, ay, bx, by, rand_small(), rand_small()};
      end
      PAIR_CROSSING: begin
        // Both segments pass through (cx, cy) at their midpoints.
        w = {cx - ax, cy - ay, cx + ax, cy + ay, cx - bx, cy - by, cx + bx, cy + by};
      end
      PAIR_PARALLEL: begin
        // Second direction is a whole multiple of the first, either sign.
        if ($urandom_range(0, 1)) k = -k;
        w = {cx, cy, cx + ax, cy + ay, bx, by, bx + ax * k, by + ay * k};
      end
      PAIR_SHARED: begin
        // The segments meet at an endpoint, so the parameter is zero or one.
        w = {cx, cy, ax, ay, ax, ay, bx, by};
        if ($urandom_range(0, 1)) w = {ax, ay, cx, cy, bx, by, ax, ay};
      end
      PAIR_NEAR: begin
        // Nearly parallel lines, so the crossing point lies far out.
        w = {cx, cy, cx + ax, cy + ay, bx, by, bx + ax, by + ay + 1};
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Holds one word on the channel until it is taken, then records its
  // expected result and idles the channel for a random gap, which may be zero.
  task automatic send_word(sit_pkg::seg_word_t w, sit_pkg::res_word_t want);
    int gap;
    seg <= w;
    seg_valid <= 1'b1;
    do @(posedge clk); while (seg_stall);
    expected_q = {expected_q, want};
    gap = gap_length();
    if (gap > 0) begin
      seg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    seg_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Directed words: degenerate pairs, the extremes of the coordinate range,
  // a clean crossing, endpoint touches and a far crossing that saturates.
  row_t directed[] = '{
    '{'{ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{1'b0, 1'b1, ZERO, ZERO}},
    '{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 1'b1, '{1'b0, 1'b1, ZERO, ZERO}},
    '{'{MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC}, 1'b1, '{1'b0, 1'b1, ZERO, ZERO}},
    '{'{ZERO, ZERO, TWO, TWO, ZERO, TWO, TWO, ZERO}, 1'b1, '{1'b1, 1'b0, ONE, ONE}},
    '{'{ZERO, ZERO, TWO, ZERO, TWO, ZERO, TWO, TWO}, 1'b1, '{1'b0, 1'b0, TWO, ZERO}},
    '{'{ZERO, ZERO, TWO, ZERO, ZERO, ZERO, ZERO, TWO}, 1'b1, '{1'b0, 1'b0, ZERO, ZERO}},
    '{'{ZERO, ZERO, TWO, ZERO, ONE, ONE, ONE, TWO}, 1'b1, '{1'b0, 1'b0, ONE, ZERO}},
    '{'{ZERO, ZERO, TWO, ZERO, ONE, ZERO, ONE, TWO}, 1'b1, '{1'b0, 1'b0, ONE, ZERO}},
    '{'{ZERO, ZERO, TWO, ZERO, ZERO, ONE, TWO, ONE}, 1'b1, '{1'b0, 1'b1, ZERO, ZERO}},
    '{'{ZERO, ZERO, ONE, ZERO, TWO, ZERO, TWO + ONE, ZERO}, 1'b1, '{1'b0, 1'b1, ZERO, ZERO}},
    '{'{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC}, 1'b0, '0},
    '{'{MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC}, 1'b0, '0},
    '{'{MAXC, ZERO, MINC, ZERO, ZERO, MAXC, ZERO, MINC}, 1'b0, '0},
    '{'{ZERO, ZERO, MAXC, 32'sd1, ZERO, 32'sd2, MAXC, 32'sd4}, 1'b0, '0},
    '{'{ZERO, ZERO, MINC, 32'sd1, ZERO, 32'sd2, MINC, 32'sd4}, 1'b0, '0},
    '{'{ZERO, ZERO, 32'sd1, 32'sd1, MAXC, ZERO, MAXC, 32'sd1}, 1'b0, '0},
    '{'{ZERO, ZERO, 32'sd1, 32'sd0, MINC, ZERO, MAXC, 32'sd1}, 1'b0, '0},
    '{'{32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555,
        32'sh5555_5555, 32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa}, 1'b0, '0},
    '{'{-ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, -ONE}, 1'b1, '{1'b1, 1'b0, ZERO, ZERO}}
  };

  // Stimulus: reset, the directed table, then random pairs in phases with
  // different idling, one phase sent with no gaps at all.
  initial begin
    pair_kind_e kind;
    sit_pkg::seg_word_t w;
    rst = 1'b1;
    seg_valid = 1'b0;
    seg = '0;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_word(directed[i].w,
                directed[i].check_typed ? directed[i].r : predict_crossing(directed[i].w));
    end

    // Hold off until the pipeline has emptied before the random part.
    wait_drained();

    for (int n = 0; n < RAND_WORDS; n++) begin
      no_idle = (n >= 300 && n < 450);
      case ($urandom_range(0, 9))
        0, 1:    kind = PAIR_ANY;
        2:       kind = PAIR_SMALL;
        3, 4, 5: kind = PAIR_CROSSING;
        6:       kind = PAIR_PARALLEL;
        7:       kind = PAIR_SHARED;
        default: kind = PAIR_NEAR;
      endcase
      w = random_pair(kind);
      send_word(w, predict_crossing(w));
      if (n == 600) wait_drained();
    end

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stall on its own pattern, mostly short with a few
  // long holds, quiet for one stretch, and every taken word is compared with
  // the oldest expected one.
  always @(posedge clk) begin
    sit_pkg::res_word_t want;
    int roll;
    roll = $urandom_range(0, 99);
    if (rst || (cycle_count > 8000 && cycle_count < 12000)) begin
      res_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      res_stall  <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else if (roll > 98) begin
      res_stall  <= 1'b1;
      stall_hold <= $urandom_range(10, 40);
    end else begin
      res_stall <= (roll < 25);
    end

    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        error_count <= error_count + 1;
        $display("%0t: result word with none expected: %p", $time, res);
      end else begin
        want = expected_q.pop_front();
        if (res !== want) begin
          error_count <= error_count + 1;
          if (res.hit !== want.hit)
            $display("%0t: hit expected %b got %b", $time, want.hit, res.hit);
          if (res.parallel !== want.parallel)
            $display("%0t: parallel expected %b got %b", $time, want.parallel, res.parallel);
          if (res.cross_x !== want.cross_x)
            $display("%0t: cross_x expected %h got %h", $time, want.cross_x, res.cross_x);
          if (res.cross_y !== want.cross_y)
            $display("%0t: cross_y expected %h got %h", $time, want.cross_y, res.cross_y);
        end
      end
    end
  end

  initial begin
    res_stall = 1'b0;
    stall_hold = 0;
    error_count = 0;
    cycle_count = 0;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ===== segment_intersection_test_unit.f =====
+incdir+src
src/sit_pkg.sv
src/sit_div.sv
src/segment_intersection_test_unit.sv
verif/tb_segment_intersection_test_unit.sv
